[src/neighbor_exclusion_arbiter_top_defines.svh]
// ----------------------------------------------------------------------------
// Neighbour exclusion arbiter assertion macros
// Shared concurrent assertion forms for the arbiter RTL.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_EXCLUSION_ARBITER_TOP_DEFINES_SVH
`define NEIGHBOR_EXCLUSION_ARBITER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define NEA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define NEA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/nea_pkg.sv]
// ----------------------------------------------------------------------------
// Neighbour exclusion arbiter package
// Widths, codes, ring helpers and controller/datapath interface types.
// ----------------------------------------------------------------------------
package nea_pkg;

  localparam int RING_SIZE   = 8;
  localparam int IDX_W       = $clog2(RING_SIZE);
  localparam int COMMAND_W   = 2;
  localparam int REQUESTER_W = 4;
  localparam int GRANT_W     = 16;
  localparam int TIME_W      = 32;
  localparam int USE_W       = 32;
  localparam int WAIT_W      = 48;

  localparam logic [TIME_W-1:0] STARVATION_LIMIT_RESET = 32'd3000000;

  // Item commands
  localparam logic [COMMAND_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_REQUEST = 2'd1;
  localparam logic [COMMAND_W-1:0] CMD_RELEASE = 2'd2;

  // Requester phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HOLD = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;

  // Grant candidate selection
  localparam logic [1:0] TGT_WHO   = 2'd0;
  localparam logic [1:0] TGT_LEFT  = 2'd1;
  localparam logic [1:0] TGT_RIGHT = 2'd2;

  // Memory read address selection
  localparam logic [1:0] ADDR_WHO   = 2'd0;
  localparam logic [1:0] ADDR_TGT   = 2'd1;
  localparam logic [1:0] ADDR_RIGHT = 2'd2;
  localparam logic [1:0] ADDR_LEFT  = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic       latch;     // capture the input item
    logic       start;     // clear result flags, advance time on tick
    logic       use_inc;   // count a use, drop requester to idle
    logic       req_mark;  // mark waiting, stamp time
    logic       tgt_load;
    logic [1:0] tgt_sel;
    logic [1:0] addr_sel;
    logic       cap_wait;  // capture candidate wait and total
    logic       cap_right; // capture right precedence
    logic       decide;    // grant or withhold the candidate
    logic       load_out;
  } nea_cmd_t;

  typedef struct packed {
    logic [COMMAND_W-1:0] command;
    logic                 who_ok;
    logic                 out_free;
  } nea_status_t;

  function automatic idx_t ring_left(idx_t k);
    idx_t r;
    if (k == idx_t'(0)) r = idx_t'(RING_SIZE - 1);
    else r = k - idx_t'(1);
    return r;
  endfunction

  function automatic idx_t ring_right(idx_t k);
    idx_t r;
    if (k == idx_t'(RING_SIZE - 1)) r = idx_t'(0);
    else r = k + idx_t'(1);
    return r;
  endfunction

endpackage

[src/nea_if.sv]
// ----------------------------------------------------------------------------
// Neighbour exclusion arbiter channels
// Valid/ready channel interfaces for command items and result items.
// ----------------------------------------------------------------------------
interface nea_in_if;
  logic                          valid;
  logic                          ready;
  logic [nea_pkg::COMMAND_W-1:0]   command;
  logic [nea_pkg::REQUESTER_W-1:0] requester;

  modport source (output valid, output command, output requester, input ready);
  modport sink (input valid, input command, input requester, output ready);
endinterface

interface nea_out_if;
  logic                        valid;
  logic                        ready;
  logic [nea_pkg::GRANT_W-1:0] grant_mask;
  logic                        starvation_yield;
  logic [nea_pkg::USE_W-1:0]   use_count;
  logic [nea_pkg::WAIT_W-1:0]  total_wait;

  modport source (output valid, output grant_mask, output starvation_yield,
                  output use_count, output total_wait, input ready);
  modport sink (input valid, input grant_mask, input starvation_yield,
                input use_count, input total_wait, output ready);
endinterface

[src/nea_ctrl.sv]
// ----------------------------------------------------------------------------
// Neighbour exclusion arbiter controller
// Sequences each item through decode, use count, grant tries and report.
// ----------------------------------------------------------------------------
module nea_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nea_pkg::nea_status_t status,
  output nea_pkg::nea_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_USE_RD = 4'd2;
  localparam logic [3:0] S_USE_WR = 4'd3;
  localparam logic [3:0] S_REQ    = 4'd4;
  localparam logic [3:0] S_TRY_K  = 4'd5;
  localparam logic [3:0] S_TRY_R  = 4'd6;
  localparam logic [3:0] S_TRY_L  = 4'd7;
  localparam logic [3:0] S_TRY_D  = 4'd8;
  localparam logic [3:0] S_RPT    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       last_try;
  logic       last_try_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      last_try <= 1'b0;
    end else begin
      state    <= state_next;
      last_try <= last_try_next;
    end
  end

  always_comb begin
    state_next    = state;
    last_try_next = last_try;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.addr_sel  = nea_pkg::ADDR_WHO;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.start = 1'b1;
        if (status.who_ok && status.command == nea_pkg::CMD_REQUEST) begin
          state_next = S_REQ;
        end else if (status.who_ok && status.command == nea_pkg::CMD_RELEASE) begin
          state_next = S_USE_RD;
        end else begin
          state_next = S_RPT;
        end
      end
      S_USE_RD: begin
        state_next = S_USE_WR;
      end
      S_USE_WR: begin
        cmd.use_inc   = 1'b1;
        cmd.tgt_load  = 1'b1;
        cmd.tgt_sel   = nea_pkg::TGT_LEFT;
        last_try_next = 1'b0;
        state_next    = S_TRY_K;
      end
      S_REQ: begin
        cmd.req_mark  = 1'b1;
        cmd.tgt_load  = 1'b1;
        cmd.tgt_sel   = nea_pkg::TGT_WHO;
        last_try_next = 1'b1;
        state_next    = S_TRY_K;
      end
      S_TRY_K: begin
        cmd.addr_sel = nea_pkg::ADDR_TGT;
        state_next   = S_TRY_R;
      end
      S_TRY_R: begin
        cmd.cap_wait = 1'b1;
        cmd.addr_sel = nea_pkg::ADDR_RIGHT;
        state_next   = S_TRY_L;
      end
      S_TRY_L: begin
        cmd.cap_right = 1'b1;
        cmd.addr_sel  = nea_pkg::ADDR_LEFT;
        state_next    = S_TRY_D;
      end
      S_TRY_D: begin
        cmd.decide = 1'b1;
        if (last_try) begin
          state_next = S_RPT;
        end else begin
          // release: left neighbour done, now try the right one
          cmd.tgt_load  = 1'b1;
          cmd.tgt_sel   = nea_pkg::TGT_RIGHT;
          last_try_next = 1'b1;
          state_next    = S_TRY_K;
        end
      end
      S_RPT: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/nea_datapath.sv]
// ----------------------------------------------------------------------------
// Neighbour exclusion arbiter datapath
// Ring state, per-requester memories, grant decision and result register.
// ----------------------------------------------------------------------------
`include "neighbor_exclusion_arbiter_top_defines.svh"

module nea_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [nea_pkg::COMMAND_W-1:0]     in_command,
  input  logic [nea_pkg::REQUESTER_W-1:0]   in_requester,
  input  logic                              cfg_we,
  input  logic [nea_pkg::TIME_W-1:0]        cfg_data,
  input  nea_pkg::nea_cmd_t                 cmd,
  output nea_pkg::nea_status_t              status,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [nea_pkg::GRANT_W-1:0]       grant_mask,
  output logic                              starvation_yield,
  output logic [nea_pkg::USE_W-1:0]         use_count,
  output logic [nea_pkg::WAIT_W-1:0]        total_wait
);

  localparam int N = nea_pkg::RING_SIZE;

  // Item and control registers
  logic [nea_pkg::COMMAND_W-1:0]   cmd_q;
  logic [nea_pkg::REQUESTER_W-1:0] who_q;
  logic [nea_pkg::TIME_W-1:0]      limit;
  logic [nea_pkg::TIME_W-1:0]      now;
  logic [N-1:0][1:0]               phase;
  logic [N-1:0]                    grants;
  logic                            yield_flag;
  nea_pkg::idx_t                   tgt;

  // Per-requester memories with valid bits standing in for the zero reset
  logic [nea_pkg::TIME_W-1:0] ws_mem  [N];
  logic [nea_pkg::WAIT_W-1:0] acc_mem [N];
  logic [nea_pkg::USE_W-1:0]  use_mem [N];
  logic [N-1:0]               ws_vld;
  logic [N-1:0]               acc_vld;
  logic [N-1:0]               use_vld;
  logic [nea_pkg::TIME_W-1:0] ws_rd;
  logic [nea_pkg::WAIT_W-1:0] acc_rd;
  logic [nea_pkg::USE_W-1:0]  use_rd;
  logic                       ws_rd_ok;
  logic                       acc_rd_ok;
  logic                       use_rd_ok;

  // Grant try registers
  logic [nea_pkg::TIME_W-1:0] wait_cur;
  logic [nea_pkg::WAIT_W-1:0] acc_cur;
  logic                       prec_right;

  logic                       who_ok;
  nea_pkg::idx_t              who_idx;
  nea_pkg::idx_t              tgt_left;
  nea_pkg::idx_t              tgt_right;
  nea_pkg::idx_t              tgt_next;
  nea_pkg::idx_t              rd_addr;
  logic [nea_pkg::TIME_W-1:0] ws_val;
  logic [nea_pkg::WAIT_W-1:0] acc_val;
  logic [nea_pkg::USE_W-1:0]  use_val;
  logic [nea_pkg::USE_W-1:0]  use_next;
  logic [nea_pkg::TIME_W-1:0] nbr_wait;
  logic                       nbr_starving;
  logic                       prec_left;
  logic                       eligible;
  logic [nea_pkg::WAIT_W:0]   acc_sum;
  logic [nea_pkg::WAIT_W-1:0] acc_next;
  logic                       out_free;
  logic                       adj_hold;

  assign who_ok  = {1'b0, who_q} < (nea_pkg::REQUESTER_W + 1)'(N);
  assign who_idx = who_q[nea_pkg::IDX_W-1:0];

  assign tgt_left  = nea_pkg::ring_left(tgt);
  assign tgt_right = nea_pkg::ring_right(tgt);

  always_comb begin
    case (cmd.tgt_sel)
      nea_pkg::TGT_LEFT:  tgt_next = nea_pkg::ring_left(who_idx);
      nea_pkg::TGT_RIGHT: tgt_next = nea_pkg::ring_right(who_idx);
      default:            tgt_next = who_idx;
    endcase
  end

  always_comb begin
    unique case (cmd.addr_sel)
      nea_pkg::ADDR_TGT:   rd_addr = tgt;
      nea_pkg::ADDR_RIGHT: rd_addr = tgt_right;
      nea_pkg::ADDR_LEFT:  rd_addr = tgt_left;
      default:             rd_addr = who_idx;
    endcase
  end

  assign ws_val  = ws_rd_ok  ? ws_rd  : '0;
  assign acc_val = acc_rd_ok ? acc_rd : '0;
  assign use_val = use_rd_ok ? use_rd : '0;

  assign use_next = (use_val == '1) ? use_val : use_val + 1'b1;

  // Neighbour wait from the word read this cycle (right in TRY_L, left in TRY_D)
  assign nbr_wait     = now - ws_val;
  assign nbr_starving = (nbr_wait > wait_cur) && (nbr_wait > limit);
  assign prec_left    = (phase[tgt_left] == nea_pkg::PH_WAIT) && nbr_starving;

  assign eligible = (phase[tgt] == nea_pkg::PH_WAIT) &&
                    (phase[tgt_right] != nea_pkg::PH_HOLD) &&
                    (phase[tgt_left] != nea_pkg::PH_HOLD);

  assign acc_sum  = {1'b0, acc_cur} + (nea_pkg::WAIT_W + 1)'(wait_cur);
  assign acc_next = acc_sum[nea_pkg::WAIT_W] ? '1 : acc_sum[nea_pkg::WAIT_W-1:0];

  assign out_free = !out_valid || out_ready;

  assign status.command  = cmd_q;
  assign status.who_ok   = who_ok;
  assign status.out_free = out_free;

  // Memory reads, registered
  always_ff @(posedge clk) begin
    ws_rd     <= ws_mem[rd_addr];
    acc_rd    <= acc_mem[rd_addr];
    use_rd    <= use_mem[rd_addr];
    ws_rd_ok  <= ws_vld[rd_addr];
    acc_rd_ok <= acc_vld[rd_addr];
    use_rd_ok <= use_vld[rd_addr];
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (cmd.req_mark) ws_mem[who_idx] <= now;
    if (cmd.use_inc) use_mem[who_idx] <= use_next;
    if (cmd.decide && eligible && !(prec_right || prec_left)) acc_mem[tgt] <= acc_next;
  end

  // Payload registers of the item and the try
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_q <= in_command;
      who_q <= in_requester;
    end
    if (cmd.tgt_load) tgt <= tgt_next;
    if (cmd.cap_wait) begin
      wait_cur <= now - ws_val;
      acc_cur  <= acc_val;
    end
    if (cmd.cap_right) prec_right <= (phase[tgt_right] == nea_pkg::PH_WAIT) && nbr_starving;
  end

  // Ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= nea_pkg::STARVATION_LIMIT_RESET;
      now        <= '0;
      phase      <= '0;
      ws_vld     <= '0;
      acc_vld    <= '0;
      use_vld    <= '0;
      grants     <= '0;
      yield_flag <= 1'b0;
    end else begin
      if (cfg_we) limit <= cfg_data;
      if (cmd.start) begin
        grants     <= '0;
        yield_flag <= 1'b0;
        if (cmd_q == nea_pkg::CMD_TICK) now <= now + 1'b1;
      end
      if (cmd.req_mark) begin
        phase[who_idx]  <= nea_pkg::PH_WAIT;
        ws_vld[who_idx] <= 1'b1;
      end
      if (cmd.use_inc) begin
        phase[who_idx]   <= nea_pkg::PH_IDLE;
        use_vld[who_idx] <= 1'b1;
      end
      if (cmd.decide && eligible) begin
        if (prec_right || prec_left) begin
          yield_flag <= 1'b1;
        end else begin
          phase[tgt]   <= nea_pkg::PH_HOLD;
          acc_vld[tgt] <= 1'b1;
          grants[tgt]  <= 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      grant_mask       <= nea_pkg::GRANT_W'(grants);
      starvation_yield <= yield_flag;
      use_count        <= who_ok ? use_val : '0;
      total_wait       <= who_ok ? acc_val : '0;
    end
  end

  // Two ring neighbours never hold at once
  always_comb begin
    adj_hold = 1'b0;
    for (int k = 0; k < N; k++) begin
      if (phase[k] == nea_pkg::PH_HOLD &&
          phase[nea_pkg::ring_right(nea_pkg::idx_t'(k))] == nea_pkg::PH_HOLD) begin
        adj_hold = 1'b1;
      end
    end
  end

  function automatic logic [N-1:0] adj_hold_vec();
    logic [N-1:0] v;
    for (int k = 0; k < N; k++) v[k] = (phase[k] == nea_pkg::PH_HOLD);
    return v;
  endfunction

  `NEA_ASSERT_NOW(a_excl, clk, rst, 1'b1, !adj_hold, "neighbours holding together")
  `NEA_ASSERT_NOW(a_grant_held, clk, rst, 1'b1, (grants & ~adj_hold_vec()) == '0, "granted requester not holding")
  `NEA_ASSERT_NOW(a_no_overrun, clk, rst, cmd.load_out, out_free, "result register overwritten")
  `NEA_ASSERT_NEXT(a_tick_only, clk, rst, cmd.start && cmd_q != nea_pkg::CMD_TICK, $stable(now), "time advanced without tick")

endmodule

[src/neighbor_exclusion_arbiter_top.sv]
// ----------------------------------------------------------------------------
// Neighbour exclusion arbiter
// Grants a shared resource to requesters on a ring with neighbour exclusion.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per handshake: command (tick, request, release)
//   and the requester index. out_ch returns exactly one result item per input
//   item: newly granted requesters, a starvation yield flag, and the use count
//   and total wait of the named requester (zero when the index is off the ring).
//   cfg_we/cfg_data write the starvation limit; write only while idle.
// Sequencing:
//   The controller runs one item at a time through a single read port on the
//   per-requester memories. A tick, an unused command or an off-ring index
//   goes from decode straight to report; a request runs one grant try (target,
//   right and left neighbour reads, then decide); a release runs the use count
//   update and two grant tries, left neighbour first. The next item is accepted
//   the cycle after the result is loaded.
// Reset:
//   rst clears all phases to idle, time to zero, the limit to 3000000 and the
//   stored statistics (through per-entry valid bits, no clearing pass).
// Stall:
//   The result register holds while out_ch.ready is low; the next item is
//   still accepted and runs up to its report, then waits for the register.
// ----------------------------------------------------------------------------
module neighbor_exclusion_arbiter_top (
  input  logic                       clk,
  input  logic                       rst,
  nea_in_if.sink                     in_ch,
  nea_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [nea_pkg::TIME_W-1:0] cfg_data
);

  nea_pkg::nea_cmd_t    cmd;
  nea_pkg::nea_status_t status;

  // Sequence each item
  nea_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold ring state, memories and the result register
  nea_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .in_command       (in_ch.command),
    .in_requester     (in_ch.requester),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .grant_mask       (out_ch.grant_mask),
    .starvation_yield (out_ch.starvation_yield),
    .use_count        (out_ch.use_count),
    .total_wait       (out_ch.total_wait)
  );

endmodule
